// ----- design/spq_pkg.sv -----
// spq_pkg: shared types and codes for the sorted priority queue
// no dependencies; used by spq_cell and sorted_priority_queue
`timescale 1ns / 1ps

package spq_pkg;

    // widths fixed by the item fields
    localparam int unsigned FIELD_KEY_BITS = 16;
    localparam int unsigned TAG_BITS       = 8;
    localparam int unsigned FILL_BITS      = 5;

    // default configuration
    localparam int unsigned DEF_DEPTH    = 16;
    localparam int unsigned DEF_KEY_BITS = 16;

    // operation codes carried on the kind field
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ----- design/sorted_priority_queue.sv -----
// sorted_priority_queue: fixed-depth priority queue in ascending key order
// depends on spq_pkg and spq_cell (one cell per queue slot)
//
// usage:
//   input channel (i_valid / o_ready) carries i_kind, i_key, i_tag; kind
//   insert places the entry behind all held entries with key <= i_key, so
//   equal keys leave in arrival order; kind remove takes the smallest entry
//   output channel (o_valid / i_ready) carries one result per input
//   transfer: o_out_key, o_out_tag, o_status and o_fill (entries held after
//   the item); key and tag are zero for inserts and errors
//   the result is registered and shown the cycle after the input transfer
//   throughput: one item per cycle while o_ready is high; every cell
//   compares its key with the incoming key and shifts in the same cycle,
//   so the whole row of cells settles an insert or remove together
//   a single output register sits between the sides; while it holds an
//   untaken result and i_ready is low, o_ready is low and the queue holds
//   reset: synchronous, active low; the queue is empty and no result is
//   pending; cell contents are not cleared
`timescale 1ns / 1ps

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH    = DEF_DEPTH,
    parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_kind,
    input  logic [FIELD_KEY_BITS-1:0] i_key,
    input  logic [TAG_BITS-1:0]       i_tag,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [FIELD_KEY_BITS-1:0] o_out_key,
    output logic [TAG_BITS-1:0]       o_out_tag,
    output logic [1:0]                o_status,
    output logic [FILL_BITS-1:0]      o_fill
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic                      in_xfer;
    logic                      full, empty;
    t_cell_ctl                 ctl;
    logic [KEY_BITS-1:0]       new_key;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic                      r_out_vld, n_out_vld;
    logic [FIELD_KEY_BITS-1:0] r_out_key, n_out_key;
    logic [TAG_BITS-1:0]       r_out_tag, n_out_tag;
    t_status                   r_status, n_status;
    logic [FILL_BITS-1:0]      r_fill, n_fill;

    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [TAG_BITS-1:0] cell_tag [DEPTH];
    logic                cell_le  [DEPTH];

    // input transfer when the output register is free or being drained
    assign o_ready = !r_out_vld || i_ready;
    assign in_xfer = i_valid && o_ready;

    assign full    = (r_cnt == FULL_CNT);
    assign empty   = (r_cnt == '0);
    assign new_key = KEY_BITS'(i_key);

    // command to the cells; dropped inserts and empty removes leave them be
    always_comb begin
        ctl.ins = in_xfer && (t_kind'(i_kind) == KIND_INSERT) && !full;
        ctl.rem = in_xfer && (t_kind'(i_kind) == KIND_REMOVE) && !empty;
    end

    // row of cells, slot 0 holds the smallest key
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                left_le;
        logic [KEY_BITS-1:0] left_key;
        logic [TAG_BITS-1:0] left_tag;
        logic [KEY_BITS-1:0] right_key;
        logic [TAG_BITS-1:0] right_tag;

        if (g == 0) begin : g_head
            assign left_le  = 1'b1;
            assign left_key = new_key;
            assign left_tag = i_tag;
        end else begin : g_body
            assign left_le  = cell_le[g-1];
            assign left_key = cell_key[g-1];
            assign left_tag = cell_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_key = cell_key[g];
            assign right_tag = cell_tag[g];
        end else begin : g_inner
            assign right_key = cell_key[g+1];
            assign right_tag = cell_tag[g+1];
        end

        spq_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_new_key   (new_key),
            .i_new_tag   (i_tag),
            .i_occ       (CW'(g) < r_cnt),
            .i_left_le   (left_le),
            .i_left_key  (left_key),
            .i_left_tag  (left_tag),
            .i_right_key (right_key),
            .i_right_tag (right_tag),
            .o_key       (cell_key[g]),
            .o_tag       (cell_tag[g]),
            .o_le        (cell_le[g])
        );
    end

    // fill count and result
    always_comb begin
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld && !i_ready;
        n_out_key = r_out_key;
        n_out_tag = r_out_tag;
        n_status  = r_status;
        n_fill    = r_fill;
        if (in_xfer) begin
            n_out_vld = 1'b1;
            n_out_key = '0;
            n_out_tag = '0;
            n_status  = ST_OK;
            if (t_kind'(i_kind) == KIND_INSERT) begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end else begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_cnt     = r_cnt - 1'b1;
                    n_out_key = FIELD_KEY_BITS'(cell_key[0]);
                    n_out_tag = cell_tag[0];
                end
            end
            n_fill = FILL_BITS'(n_cnt);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        r_out_key <= n_out_key;
        r_out_tag <= n_out_tag;
        r_status  <= n_status;
        r_fill    <= n_fill;
    end

    assign o_valid   = r_out_vld;
    assign o_out_key = r_out_key;
    assign o_out_tag = r_out_tag;
    assign o_status  = r_status;
    assign o_fill    = r_fill;

endmodule

// ----- design/spq_cell.sv -----
// spq_cell: one slot of the shift-register priority queue
// depends on spq_pkg (t_cell_ctl, TAG_BITS)
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
#(
    parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_BITS-1:0] i_new_key,
    input  logic [TAG_BITS-1:0] i_new_tag,
    input  logic                i_occ,
    input  logic                i_left_le,
    input  logic [KEY_BITS-1:0] i_left_key,
    input  logic [TAG_BITS-1:0] i_left_tag,
    input  logic [KEY_BITS-1:0] i_right_key,
    input  logic [TAG_BITS-1:0] i_right_tag,
    output logic [KEY_BITS-1:0] o_key,
    output logic [TAG_BITS-1:0] o_tag,
    output logic                o_le
);

    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TAG_BITS-1:0] r_tag, n_tag;

    // held entry stays ahead of the new one when its key is not larger
    assign o_le = i_occ && (r_key <= i_new_key);

    // insert: keep, take the new entry, or take the left neighbour's entry
    // remove: take the right neighbour's entry
    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctl.ins) begin
            if (o_le) begin
                n_key = r_key;
                n_tag = r_tag;
            end else if (i_left_le) begin
                n_key = i_new_key;
                n_tag = i_new_tag;
            end else begin
                n_key = i_left_key;
                n_tag = i_left_tag;
            end
        end else if (i_ctl.rem) begin
            n_key = i_right_key;
            n_tag = i_right_tag;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule
